// File: hw/rtl/link_reconnect_backoff_fsm_top_defines.svh
// assertion macros used by the checker file
`ifndef LINK_RECONNECT_BACKOFF_FSM_TOP_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_FSM_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define LRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lrb_pkg.sv
// types, codes and constants of the link reconnect backoff supervisor
package lrb_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // link modes, also the state codes of the supervisor
    localparam logic [MODE_W-1:0] MODE_IDLE       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECTING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONNECTED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BACKOFF    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 2'd2;

    // configuration reset values
    localparam logic [TIME_W-1:0] RST_INITIAL_DELAY = 32'd1000;
    localparam logic [TIME_W-1:0] RST_MAX_DELAY     = 32'd60000;
    localparam logic [TIME_W-1:0] RST_TIMEOUT       = 32'd10000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_connected;
        logic [TIME_W-1:0] retry_delay_ms;
        logic              start_attempt;
        logic              drop_link;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] initial_retry_delay_ms;
        logic [TIME_W-1:0] max_retry_delay_ms;
        logic [TIME_W-1:0] connect_timeout_ms;
    } t_cfg;

endpackage

// File: hw/rtl/lrb_cfg_regs.sv
// configuration register bank of the backoff supervisor
module lrb_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [lrb_pkg::TIME_W-1:0]    i_wr_data,
    output lrb_pkg::t_cfg                 o_cfg
);
    import lrb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_retry_delay_ms <= RST_INITIAL_DELAY;
            r_cfg.max_retry_delay_ms     <= RST_MAX_DELAY;
            r_cfg.connect_timeout_ms     <= RST_TIMEOUT;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_INITIAL_DELAY: r_cfg.initial_retry_delay_ms <= i_wr_data;
                CFG_MAX_DELAY:     r_cfg.max_retry_delay_ms     <= i_wr_data;
                CFG_TIMEOUT:       r_cfg.connect_timeout_ms     <= i_wr_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/lrb_core.sv
// supervisor state registers and the combinational step logic
module lrb_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  lrb_pkg::t_in_item  i_item,
    input  lrb_pkg::t_cfg      i_cfg,
    output lrb_pkg::t_out_item o_result
);
    import lrb_pkg::*;

    logic [MODE_W-1:0] r_mode,  n_mode;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_due,   n_due;
    logic [TIME_W-1:0] r_delay, n_delay;

    logic [TIME_W:0]   doubled;
    logic [TIME_W-1:0] backoff_delay;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_due;
    logic              timed_out;
    logic              due_reached;
    logic              start_attempt;
    logic              drop_link;

    // doubling with saturation at the ceiling, carry out counts as overflow
    assign doubled       = {r_delay, 1'b0};
    assign backoff_delay = (doubled[TIME_W] || (doubled[TIME_W-1:0] > i_cfg.max_retry_delay_ms))
                         ? i_cfg.max_retry_delay_ms : doubled[TIME_W-1:0];

    // wrap-safe elapsed checks
    assign since_start = i_item.now_ms - r_start;
    assign since_due   = i_item.now_ms - r_due;
    assign timed_out   = (since_start >= i_cfg.connect_timeout_ms);
    assign due_reached = !since_due[TIME_W-1];

    always_comb begin
        n_mode        = r_mode;
        n_start       = r_start;
        n_due         = r_due;
        n_delay       = r_delay;
        start_attempt = 1'b0;
        drop_link     = 1'b0;
        case (i_item.command)
            CMD_BEGIN: begin
                n_delay       = i_cfg.initial_retry_delay_ms;
                n_start       = i_item.now_ms;
                n_mode        = MODE_CONNECTING;
                start_attempt = 1'b1;
            end
            CMD_STOP: begin
                n_mode    = MODE_IDLE;
                n_delay   = '0;
                drop_link = 1'b1;
            end
            CMD_TICK: begin
                case (r_mode)
                    MODE_CONNECTING: begin
                        if (i_item.link_up) begin
                            n_mode  = MODE_CONNECTED;
                            n_delay = i_cfg.initial_retry_delay_ms;
                        end else if (timed_out) begin
                            drop_link = 1'b1;
                            n_due     = i_item.now_ms + r_delay;
                            n_mode    = MODE_BACKOFF;
                            n_delay   = backoff_delay;
                        end
                    end
                    MODE_CONNECTED: begin
                        if (!i_item.link_up) begin
                            drop_link = 1'b1;
                            n_due     = i_item.now_ms + r_delay;
                            n_mode    = MODE_BACKOFF;
                            n_delay   = backoff_delay;
                        end
                    end
                    MODE_BACKOFF: begin
                        if (due_reached) begin
                            n_start       = i_item.now_ms;
                            n_mode        = MODE_CONNECTING;
                            start_attempt = 1'b1;
                        end
                    end
                    default: ; // idle holds
                endcase
            end
            default: ; // unused command, state kept
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_due   <= '0;
            r_delay <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_due   <= n_due;
            r_delay <= n_delay;
        end
    end

    assign o_result.mode           = n_mode;
    assign o_result.is_connected   = (n_mode == MODE_CONNECTED);
    assign o_result.retry_delay_ms = n_delay;
    assign o_result.start_attempt  = start_attempt;
    assign o_result.drop_link      = drop_link;

endmodule

// File: hw/rtl/link_reconnect_backoff_fsm_top.sv
// link supervisor with exponential reconnect backoff, top level
// path: input register, then result register; the step logic between them is
//   a few compares, two adds and a shift, and the state updates in the same cycle
// throughput: one beat per cycle while the result channel is not stalled
// reset: synchronous active-low i_rst_n clears both pipeline valids, returns the
//   supervisor to idle with zero delay and loads the register defaults
module link_reconnect_backoff_fsm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lrb_pkg::t_in_item             i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lrb_pkg::t_out_item            o_out_data,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrb_pkg::TIME_W-1:0]    i_cfg_data
);
    import lrb_pkg::*;

    t_cfg      cfg;
    t_out_item step_result;

    // input register stage
    logic      r_in_vld;
    t_in_item  r_in_item;
    // result register stage
    logic      r_out_vld;
    t_out_item r_out_item;

    logic      in_accept;
    logic      step;

    // the item in the input register moves on when the result slot is free or
    // is being drained this cycle; the state registers update on the same edge
    assign step       = r_in_vld && (!r_out_vld || !i_out_stall);
    // input register frees up when its item steps, so a beat per cycle flows
    assign o_in_stall = r_in_vld && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration is taken at any time; software is to write only while idle, not enforced here
    assign o_cfg_ready = 1'b1;

    lrb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    lrb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_data;
        end
        if (step) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule

// File: hw/rtl/lrb_checker.sv
// port-level checker for the backoff supervisor, bound to the top level
`include "link_reconnect_backoff_fsm_top_defines.svh"

module lrb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lrb_pkg::t_out_item o_out_data
);
    import lrb_pkg::*;

    // connected flag tracks the reported mode
    `LRB_ASSERT_NOW(a_conn_flag, o_out_valid, o_out_data.is_connected == (o_out_data.mode == MODE_CONNECTED), "is_connected disagrees with mode")

    // a new attempt always leaves the supervisor connecting, with no drop
    `LRB_ASSERT_NOW(a_start_mode, o_out_valid && o_out_data.start_attempt, o_out_data.mode == MODE_CONNECTING && !o_out_data.drop_link, "start_attempt outside connecting")

    // a drop leaves the supervisor idle or in backoff
    `LRB_ASSERT_NOW(a_drop_mode, o_out_valid && o_out_data.drop_link, o_out_data.mode == MODE_IDLE || o_out_data.mode == MODE_BACKOFF, "drop_link into wrong mode")

    // a stalled result beat holds
    `LRB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result beat changed")

endmodule

bind link_reconnect_backoff_fsm_top lrb_checker u_lrb_checker (.*);
